>>> src/tcpg_pkg.sv
// ----------------------------------------------------------------------------
// tcpg_pkg
// Shared widths, colors, register codes and the card geometry record for the
// test card pixel generator.
// ----------------------------------------------------------------------------
package tcpg_pkg;

  localparam int CoordW     = 11;
  localparam int SideW      = 11;
  localparam int ArgbW      = 32;
  localparam int ApbAddrW   = 4;
  localparam int ApbDataW   = 32;
  localparam int DefMaxSide = 1024;
  localparam int DefMinSide = 16;
  localparam int Sixteenths = 16;

  localparam logic [SideW-1:0] RstCardSide      = SideW'(64);
  localparam logic             RstAlphaStraight = 1'b1;
  localparam logic             RstPhaseSecond   = 1'b0;

  // floor(n/3) = (n * Recip3) >> Recip3Shift for n below 2**16
  localparam int               Recip3Shift = 17;
  localparam logic [16:0]      Recip3      = 17'd43691;

  typedef enum logic [1:0] {
    RegCardSide      = 2'd0,
    RegAlphaStraight = 2'd1,
    RegPhaseSecond   = 2'd2
  } reg_idx_t;

  function automatic logic [ArgbW-1:0] pack_argb(input logic [7:0] a, input logic [7:0] r,
                                                 input logic [7:0] g, input logic [7:0] b);
    return {a, r, g, b};
  endfunction

  localparam logic [ArgbW-1:0] ColGround        = pack_argb(8'd255, 8'd32, 8'd34, 8'd38);
  localparam logic [ArgbW-1:0] ColWhite         = pack_argb(8'd255, 8'd255, 8'd255, 8'd255);
  localparam logic [ArgbW-1:0] ColBlack         = pack_argb(8'd255, 8'd0, 8'd0, 8'd0);
  localparam logic [ArgbW-1:0] ColRed           = pack_argb(8'd255, 8'd255, 8'd0, 8'd0);
  localparam logic [ArgbW-1:0] ColGreen         = pack_argb(8'd255, 8'd0, 8'd255, 8'd0);
  localparam logic [ArgbW-1:0] ColBlue          = pack_argb(8'd255, 8'd0, 8'd0, 8'd255);
  localparam logic [ArgbW-1:0] ColMidGrey       = pack_argb(8'd255, 8'd188, 8'd188, 8'd188);
  localparam logic [ArgbW-1:0] ColPhase1        = pack_argb(8'd255, 8'd0, 8'd220, 8'd220);
  localparam logic [ArgbW-1:0] ColPhase2        = pack_argb(8'd255, 8'd240, 8'd210, 8'd0);
  localparam logic [ArgbW-1:0] ColHalfStraight  = pack_argb(8'd128, 8'd255, 8'd255, 8'd255);
  localparam logic [ArgbW-1:0] ColHalfPremul    = pack_argb(8'd128, 8'd128, 8'd128, 8'd128);
  localparam logic [ArgbW-1:0] ColClearStraight = pack_argb(8'd0, 8'd255, 8'd0, 8'd255);
  localparam logic [ArgbW-1:0] ColClearPremul   = pack_argb(8'd0, 8'd0, 8'd0, 8'd0);

  typedef struct packed {
    logic [SideW-1:0] side;
    logic [SideW-1:0] side_m1;
    logic [SideW-1:0] side_m2;
    logic [SideW-1:0] p1;
    logic [SideW-1:0] p3;
    logic [SideW-1:0] p4;
    logic [SideW-1:0] p6;
    logic [SideW-1:0] p8;
    logic [SideW-1:0] p10;
    logic [SideW-1:0] p11;
    logic [SideW-1:0] p14;
    logic [SideW-1:0] p15;
    logic [SideW-1:0] e1;
    logic [SideW-1:0] e2;
    logic             too_small;
    logic             alpha_straight;
    logic             phase_second;
  } geom_t;

  function automatic logic [SideW-1:0] sixteenth(input logic [SideW-1:0] s,
                                                 input logic [3:0] k);
    logic [SideW+3:0] prod;
    prod = (SideW+4)'(s) * (SideW+4)'(k);
    return prod[SideW+3:4];
  endfunction

  function automatic logic in_span(input logic [CoordW-1:0] v, input logic [SideW-1:0] lo,
                                   input logic [SideW-1:0] hi);
    return (v >= lo) && (v < hi);
  endfunction

endpackage

>>> src/test_card_pixel_generator_unit.sv
// ----------------------------------------------------------------------------
// test_card_pixel_generator_unit
// Diagnostic test card source: one texel coordinate in, one ARGB word out.
//
//   channel  handshake             payload
//   input    in_valid / in_ready   pos_x, pos_y
//   output   out_valid / out_ready argb_word, side_too_small
//   config   APB psel ... pready   paddr, pwdata, prdata
//
// one word per clock while out_ready is high and no register write is settling
// each word passes an input register, the region decode and the output register
// a full output register holds its word and stalls the input register behind it
// in_ready is low on every register write cycle, and after it and after reset
// for as long as hold_d1 or hold_d2 is set, while the geometry registers settle
// ----------------------------------------------------------------------------
module test_card_pixel_generator_unit #(
  parameter int MAX_SIDE = tcpg_pkg::DefMaxSide,
  parameter int MIN_SIDE = tcpg_pkg::DefMinSide
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcpg_pkg::ApbAddrW-1:0] paddr,
  input  logic [tcpg_pkg::ApbDataW-1:0] pwdata,
  output logic [tcpg_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tcpg_pkg::CoordW-1:0]   pos_x,
  input  logic [tcpg_pkg::CoordW-1:0]   pos_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcpg_pkg::ArgbW-1:0]    argb_word,
  output logic                          side_too_small
);
  import tcpg_pkg::*;

  geom_t             geom;
  logic              settle;
  logic              v1;
  logic [CoordW-1:0] x1;
  logic [CoordW-1:0] y1;
  logic              adv2;
  logic              load1;
  logic [ArgbW-1:0]  argb_next;
  logic              too_small_next;

  tcpg_regs #(
    .MAX_SIDE(MAX_SIDE),
    .MIN_SIDE(MIN_SIDE)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .geom   (geom),
    .settle (settle)
  );

  tcpg_shade u_shade (
    .x        (x1),
    .y        (y1),
    .geom     (geom),
    .argb     (argb_next),
    .too_small(too_small_next)
  );

  assign adv2     = !out_valid || out_ready;
  assign load1    = !v1 || adv2;
  assign in_ready = load1 && !settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load1) v1 <= in_valid && !settle;
      if (adv2) out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x1 <= pos_x;
      y1 <= pos_y;
    end
    if (adv2 && v1) begin
      argb_word      <= argb_next;
      side_too_small <= too_small_next;
    end
  end

  a_write_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite) |-> !in_ready)
    else $error("word accepted during a register write");

  a_write_settles: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite) |=> !in_ready)
    else $error("word accepted before geometry settled");

  a_small_gives_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && side_too_small) |-> (argb_word == '0))
    else $error("nonzero word with undersized card");

endmodule

>>> src/tcpg_regs.sv
// ----------------------------------------------------------------------------
// tcpg_regs
// Configuration registers behind the APB port, and the registered card
// geometry derived from them in two steps.
// ----------------------------------------------------------------------------
module tcpg_regs #(
  parameter int MAX_SIDE = tcpg_pkg::DefMaxSide,
  parameter int MIN_SIDE = tcpg_pkg::DefMinSide
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcpg_pkg::ApbAddrW-1:0] paddr,
  input  logic [tcpg_pkg::ApbDataW-1:0] pwdata,
  output logic [tcpg_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  output tcpg_pkg::geom_t               geom,
  output logic                          settle
);
  import tcpg_pkg::*;

  logic [SideW-1:0] card_side;
  logic             alpha_straight;
  logic             phase_second;
  logic             wr;
  logic             hold_d1;
  logic             hold_d2;

  logic [SideW-1:0] side_a;
  logic             too_small_a;
  logic [SideW-1:0] p1_a, p3_a, p4_a, p6_a, p8_a, p10_a, p11_a, p14_a, p15_a;
  logic [SideW-1:0] side_sat;
  logic [SideW-1:0] span;
  logic [SideW:0]   span2;
  logic [27:0]      prod1;
  logic [28:0]      prod2;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign settle = wr || hold_d1 || hold_d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      card_side      <= RstCardSide;
      alpha_straight <= RstAlphaStraight;
      phase_second   <= RstPhaseSecond;
      hold_d1        <= 1'b1;
      hold_d2        <= 1'b1;
    end else begin
      hold_d1 <= wr;
      hold_d2 <= hold_d1;
      if (wr) begin
        case (paddr[3:2])
          RegCardSide:      card_side      <= pwdata[SideW-1:0];
          RegAlphaStraight: alpha_straight <= pwdata[0];
          RegPhaseSecond:   phase_second   <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegCardSide:      prdata = ApbDataW'(card_side);
      RegAlphaStraight: prdata = ApbDataW'(alpha_straight);
      RegPhaseSecond:   prdata = ApbDataW'(phase_second);
      default:          prdata = '0;
    endcase
  end

  // first step: saturate side and take the sixteenths
  assign side_sat = (32'(card_side) > 32'(MAX_SIDE)) ? SideW'(MAX_SIDE) : card_side;

  always_ff @(posedge clk) begin
    side_a      <= side_sat;
    too_small_a <= 32'(card_side) < 32'(MIN_SIDE);
    p1_a        <= sixteenth(side_sat, 4'd1);
    p3_a        <= sixteenth(side_sat, 4'd3);
    p4_a        <= sixteenth(side_sat, 4'd4);
    p6_a        <= sixteenth(side_sat, 4'd6);
    p8_a        <= sixteenth(side_sat, 4'd8);
    p10_a       <= sixteenth(side_sat, 4'd10);
    p11_a       <= sixteenth(side_sat, 4'd11);
    p14_a       <= sixteenth(side_sat, 4'd14);
    p15_a       <= sixteenth(side_sat, 4'd15);
  end

  // second step: bar edges at a third and two thirds of the span
  assign span  = p15_a - p1_a;
  assign span2 = {span, 1'b0};
  assign prod1 = 28'(span) * 28'(Recip3);
  assign prod2 = 29'(span2) * 29'(Recip3);

  always_ff @(posedge clk) begin
    geom.side           <= side_a;
    geom.side_m1        <= side_a - SideW'(1);
    geom.side_m2        <= side_a - SideW'(2);
    geom.p1             <= p1_a;
    geom.p3             <= p3_a;
    geom.p4             <= p4_a;
    geom.p6             <= p6_a;
    geom.p8             <= p8_a;
    geom.p10            <= p10_a;
    geom.p11            <= p11_a;
    geom.p14            <= p14_a;
    geom.p15            <= p15_a;
    geom.e1             <= p1_a + SideW'(prod1 >> Recip3Shift);
    geom.e2             <= p1_a + SideW'(prod2 >> Recip3Shift);
    geom.too_small      <= too_small_a;
    geom.alpha_straight <= alpha_straight;
    geom.phase_second   <= phase_second;
  end

endmodule

>>> src/tcpg_shade.sv
// ----------------------------------------------------------------------------
// tcpg_shade
// Region decode and color selection for one texel, later regions winning and
// the two border rings on top.
// ----------------------------------------------------------------------------
module tcpg_shade (
  input  logic [tcpg_pkg::CoordW-1:0] x,
  input  logic [tcpg_pkg::CoordW-1:0] y,
  input  tcpg_pkg::geom_t             geom,
  output logic [tcpg_pkg::ArgbW-1:0]  argb,
  output logic                        too_small
);
  import tcpg_pkg::*;

  logic [ArgbW-1:0] c;
  logic             outside;
  logic             ring_out;
  logic             ring_in;
  logic             band_bars;
  logic             band_alpha;
  logic             band_stripe;
  logic             band_phase;

  assign outside     = (x >= geom.side) || (y >= geom.side);
  assign band_bars   = in_span(y, geom.p3, geom.p6);
  assign band_alpha  = in_span(y, geom.p6, geom.p10);
  assign band_stripe = in_span(y, geom.p10, geom.p14);
  assign band_phase  = in_span(y, geom.p14, geom.p15);

  assign ring_out = (x == '0) || (y == '0) || (x == geom.side_m1) || (y == geom.side_m1);
  assign ring_in  = (x >= CoordW'(1)) && (y >= CoordW'(1)) &&
                    (x < geom.side_m1) && (y < geom.side_m1) &&
                    ((x == CoordW'(1)) || (y == CoordW'(1)) ||
                     (x == geom.side_m2) || (y == geom.side_m2));

  always_comb begin
    c = ColGround;
    if (in_span(x, geom.p1, geom.p3) && in_span(y, geom.p1, geom.p3)) c = ColWhite;
    if (band_bars && in_span(x, geom.p1, geom.e1)) c = ColRed;
    if (band_bars && in_span(x, geom.e1, geom.e2)) c = ColGreen;
    if (band_bars && in_span(x, geom.e2, geom.p15)) c = ColBlue;
    if (band_alpha && in_span(x, geom.p1, geom.p4))
      c = geom.alpha_straight ? ColHalfStraight : ColHalfPremul;
    if (band_alpha && in_span(x, geom.p4, geom.p8))
      c = geom.alpha_straight ? ColClearStraight : ColClearPremul;
    if (band_alpha && in_span(x, geom.p8, geom.p11))
      c = (x[0] ^ y[0]) ? ColBlack : ColWhite;
    if (band_alpha && in_span(x, geom.p11, geom.p15)) c = ColMidGrey;
    if (band_stripe && in_span(x, geom.p1, geom.p8)) c = x[0] ? ColBlack : ColWhite;
    if (band_stripe && in_span(x, geom.p8, geom.p15)) c = y[0] ? ColBlack : ColWhite;
    if (!geom.phase_second && band_phase && in_span(x, geom.p1, geom.p8)) c = ColPhase1;
    if (geom.phase_second && band_phase && in_span(x, geom.p8, geom.p15)) c = ColPhase2;
    if (ring_out) c = ColWhite;
    if (ring_in) c = ColBlack;
  end

  assign too_small = geom.too_small;
  assign argb      = (geom.too_small || outside) ? '0 : c;

endmodule

>>> tb/tb_test_card_pixel_generator_unit.sv
// ----------------------------------------------------------------------------
// tb_test_card_pixel_generator_unit
// Self-checking bench for the test card pixel generator. Coordinates go in on
// a valid/ready channel and ARGB words come back on another. Each returned
// word is checked against a texel predictor that runs on a shadow copy of the
// card registers. The run walks through several card sides, alpha modes and
// phase settings, including too small, saturated and zero sides. It mixes
// directed texels with random ones, with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_test_card_pixel_generator_unit;
  import tcpg_pkg::*;

  localparam int MaxSide = DefMaxSide;
  localparam int MinSide = DefMinSide;
  localparam int RandPerPhase = 125;
  localparam int NumPhases = 12;
  localparam int MaxPrints = 50;

  localparam logic [ApbAddrW-1:0] AddrCardSide = ApbAddrW'(4 * RegCardSide);
  localparam logic [ApbAddrW-1:0] AddrAlphaStraight = ApbAddrW'(4 * RegAlphaStraight);
  localparam logic [ApbAddrW-1:0] AddrPhaseSecond = ApbAddrW'(4 * RegPhaseSecond);
  localparam logic [ApbAddrW-1:0] AddrUnused = ApbAddrW'(12);

  localparam logic [31:0] TexGround = 32'hFF202226;
  localparam logic [31:0] TexWhite = 32'hFFFFFFFF;
  localparam logic [31:0] TexBlack = 32'hFF000000;
  localparam logic [31:0] TexRed = 32'hFFFF0000;
  localparam logic [31:0] TexGreen = 32'hFF00FF00;
  localparam logic [31:0] TexBlue = 32'hFF0000FF;
  localparam logic [31:0] TexMidGrey = 32'hFFBCBCBC;
  localparam logic [31:0] TexCyan = 32'hFF00DCDC;
  localparam logic [31:0] TexYellow = 32'hFFF0D200;
  localparam logic [31:0] TexHalfStraight = 32'h80FFFFFF;
  localparam logic [31:0] TexHalfPremul = 32'h80808080;
  localparam logic [31:0] TexClearStraight = 32'h00FF00FF;
  localparam logic [31:0] TexClearPremul = 32'h00000000;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } coord_t;

  typedef struct packed {
    logic [ArgbW-1:0] argb;
    logic too_small;
  } texel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CoordW-1:0] pos_x = '0;
  logic [CoordW-1:0] pos_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ArgbW-1:0] argb_word;
  logic side_too_small;

  logic [SideW-1:0] cfg_side = RstCardSide;
  logic cfg_straight = RstAlphaStraight;
  logic cfg_phase_second = RstPhaseSecond;

  coord_t pending_coords[$];
  texel_t expected_texels[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;

  test_card_pixel_generator_unit uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .argb_word(argb_word),
    .side_too_small(side_too_small)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned sixteenth_mark(input int unsigned s, input int unsigned k);
    return s * k / 16;
  endfunction

  function automatic bit box_hit(input int unsigned x, input int unsigned y,
                                 input int unsigned l, input int unsigned t,
                                 input int unsigned r, input int unsigned b);
    return x >= l && x < r && y >= t && y < b;
  endfunction

  function automatic texel_t predict_texel(input logic [CoordW-1:0] x_in,
                                           input logic [CoordW-1:0] y_in);
    int unsigned s, x, y, p1, p3, p4, p6, p8, p10, p11, p14, p15, span, e1, e2;
    texel_t t;
    logic [31:0] c;
    s = cfg_side;
    x = x_in;
    y = y_in;
    t.argb = '0;
    t.too_small = 1'b0;
    if (s > MaxSide) s = MaxSide;
    if (s < MinSide) begin
      t.too_small = 1'b1;
      return t;
    end
    if (x >= s || y >= s) return t;
    p1 = sixteenth_mark(s, 1);
    p3 = sixteenth_mark(s, 3);
    p4 = sixteenth_mark(s, 4);
    p6 = sixteenth_mark(s, 6);
    p8 = sixteenth_mark(s, 8);
    p10 = sixteenth_mark(s, 10);
    p11 = sixteenth_mark(s, 11);
    p14 = sixteenth_mark(s, 14);
    p15 = sixteenth_mark(s, 15);
    span = p15 - p1;
    e1 = p1 + span / 3;
    e2 = p1 + span * 2 / 3;
    c = TexGround;
    if (box_hit(x, y, p1, p1, p3, p3)) c = TexWhite;
    if (box_hit(x, y, p1, p3, e1, p6)) c = TexRed;
    if (box_hit(x, y, e1, p3, e2, p6)) c = TexGreen;
    if (box_hit(x, y, e2, p3, p15, p6)) c = TexBlue;
    if (box_hit(x, y, p1, p6, p4, p10)) c = cfg_straight ? TexHalfStraight : TexHalfPremul;
    if (box_hit(x, y, p4, p6, p8, p10)) c = cfg_straight ? TexClearStraight : TexClearPremul;
    if (box_hit(x, y, p8, p6, p11, p10)) c = ((x + y) % 2 == 0) ? TexWhite : TexBlack;
    if (box_hit(x, y, p11, p6, p15, p10)) c = TexMidGrey;
    if (box_hit(x, y, p1, p10, p8, p14)) c = (x % 2 == 0) ? TexWhite : TexBlack;
    if (box_hit(x, y, p8, p10, p15, p14)) c = (y % 2 == 0) ? TexWhite : TexBlack;
    if (!cfg_phase_second) begin
      if (box_hit(x, y, p1, p14, p8, p15)) c = TexCyan;
    end else begin
      if (box_hit(x, y, p8, p14, p15, p15)) c = TexYellow;
    end
    if (x == 0 || y == 0 || x == s - 1 || y == s - 1) c = TexWhite;
    if (x >= 1 && y >= 1 && x < s - 1 && y < s - 1 &&
        (x == 1 || y == 1 || x == s - 2 || y == s - 2)) c = TexBlack;
    t.argb = c;
    return t;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < MaxPrints)
      $display("error: %s got %h want %h at %0t", field, got, want, $realtime);
    mismatch_count++;
  endtask

  // coordinate driver
  always @(posedge clk) begin : coord_driver
    coord_t c;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_texels.push_back(predict_texel(pos_x, pos_y));
      if (!in_valid || in_ready) begin
        if (pending_coords.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          c = pending_coords.pop_front();
          in_valid <= 1'b1;
          pos_x <= c.x;
          pos_y <= c.y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // word monitor
  always @(posedge clk) begin : word_monitor
    texel_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_texels.size() == 0) begin
          report_mismatch("unexpected word", argb_word, '0);
        end else begin
          want = expected_texels.pop_front();
          if (argb_word !== want.argb) report_mismatch("argb_word", argb_word, want.argb);
          if (side_too_small !== want.too_small)
            report_mismatch("side_too_small", 32'(side_too_small), 32'(want.too_small));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic apb_write(input logic [ApbAddrW-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      AddrCardSide: cfg_side = data[SideW-1:0];
      AddrAlphaStraight: cfg_straight = data[0];
      AddrPhaseSecond: cfg_phase_second = data[0];
      default: ;
    endcase
  endtask

  task automatic push_coord(input int x, input int y);
    pending_coords.push_back('{x: CoordW'(x), y: CoordW'(y)});
  endtask

  task automatic push_random_coords(input int n);
    int unsigned eff, r, a, b;
    eff = (cfg_side > MaxSide) ? MaxSide : cfg_side;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (eff < MinSide || r < 20) begin
        a = $urandom_range(2047);
        b = $urandom_range(2047);
      end else if (r < 35) begin
        a = eff - 2 + $urandom_range(3);
        b = $urandom_range(eff);
      end else begin
        a = $urandom_range(eff - 1);
        b = $urandom_range(eff - 1);
      end
      if ($urandom_range(1)) push_coord(a, b);
      else push_coord(b, a);
    end
  endtask

  task automatic wait_for_drain();
    do @(negedge clk);
    while (pending_coords.size() != 0 || in_valid || expected_texels.size() != 0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      case (ph)
        0: begin
          // reset card: side 64, straight alpha, first phase
          push_coord(8, 8);     push_coord(10, 16);   push_coord(21, 16);
          push_coord(22, 16);   push_coord(40, 16);   push_coord(41, 16);
          push_coord(8, 30);    push_coord(20, 30);   push_coord(34, 30);
          push_coord(35, 30);   push_coord(50, 30);   push_coord(10, 45);
          push_coord(11, 45);   push_coord(40, 45);   push_coord(40, 46);
          push_coord(10, 57);   push_coord(40, 57);   push_coord(0, 5);
          push_coord(63, 5);    push_coord(1, 5);     push_coord(62, 62);
          push_coord(64, 0);    push_coord(0, 64);    push_coord(2047, 2047);
          push_coord(2047, 0);
        end
        1: begin
          apb_write(AddrCardSide, 32'd16);
          apb_write(AddrAlphaStraight, 32'd0);
          apb_write(AddrPhaseSecond, 32'd1);
          push_coord(15, 15); push_coord(16, 3); push_coord(8, 14); push_coord(4, 8);
        end
        2: begin
          apb_write(AddrCardSide, 32'd15);
          push_coord(0, 0); push_coord(2047, 2047);
        end
        3: begin
          apb_write(AddrCardSide, 32'd1024);
          push_coord(1023, 1023); push_coord(1024, 5); push_coord(600, 900);
        end
        4: begin
          apb_write(AddrCardSide, 32'd2047);
          apb_write(AddrAlphaStraight, 32'd1);
          apb_write(AddrPhaseSecond, 32'd0);
          push_coord(1023, 0); push_coord(1024, 1024);
        end
        5: apb_write(AddrCardSide, 32'd0);
        6: begin
          apb_write(AddrCardSide, 32'd1025);
          apb_write(AddrAlphaStraight, 32'd0);
          apb_write(AddrUnused, 32'd5);
        end
        7: begin
          apb_write(AddrCardSide, 32'd17);
          apb_write(AddrPhaseSecond, 32'd1);
        end
        default: begin
          apb_write(AddrCardSide,
                    {21'($urandom_range(32'h001F_FFFF)), SideW'($urandom_range(16, 400))});
          apb_write(AddrAlphaStraight, $urandom());
          apb_write(AddrPhaseSecond, $urandom());
        end
      endcase
      push_random_coords(RandPerPhase / 2);
      wait_for_drain();
      push_random_coords(RandPerPhase - RandPerPhase / 2);
      wait_for_drain();
    end
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("test_card_pixel_generator_unit: match");
    end else begin
      $display("test_card_pixel_generator_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("test_card_pixel_generator_unit: mismatch");
    $finish;
  end

endmodule
